// ===== hdl/pseudo_des_counter_rng_core_macros.svh =====
// assertion macros for the pseudo-des counter rng core
// used by modules that carry clk and arst_n; no other dependencies
`ifndef PSEUDO_DES_COUNTER_RNG_CORE_MACROS_SVH
`define PSEUDO_DES_COUNTER_RNG_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition that holds at every clock edge outside reset
`define PSDES_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies outcome in the cycle after it
`define PSDES_ASSERT_NEXT(lbl, trig, outcome, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (outcome)) \
		else $error(msg);

`else

`define PSDES_ASSERT(lbl, cond, msg)
`define PSDES_ASSERT_NEXT(lbl, trig, outcome, msg)

`endif

`endif

// ===== hdl/psdes_pkg.sv =====
// shared types and constants of the pseudo-des counter rng
// no dependencies
package psdes_pkg;

	localparam int unsigned ROUND_COUNT = 4;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned HALF_W      = 16;
	localparam int unsigned FRAC_W      = 23;

	// register indexes of the configuration port
	localparam logic CFG_KEY_SEED     = 1'b0;
	localparam logic CFG_COUNTER_SEED = 1'b1;

	localparam logic [WORD_W-1:0] XOR_IN [ROUND_COUNT] = '{
		32'hBAA96887, 32'h1E17D32C, 32'h03BCDC3C, 32'h0F33D1B2
	};
	localparam logic [WORD_W-1:0] XOR_OUT [ROUND_COUNT] = '{
		32'h4B0F3B58, 32'hE874F0C3, 32'h6955C5A6, 32'h55A7CA46
	};

	// one feistel block in flight between cells
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} beat_t;

endpackage

// ===== hdl/pseudo_des_counter_rng_core.sv =====
// top level of the pseudo-des counter rng: state, four round cells, output register
// depends on psdes_pkg, psdes_state and psdes_round_cell
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index (1b), cfg_data (32b)
//  draw in  | in_valid / in_ready    | restart (1b)
//  result   | out_valid / out_ready  | random_word (32b), unit_fraction (23b)
//
// one draw beat is taken per cycle while in_ready is high; each beat is registered through
// two register stages in each of the four round cells, then the output register
// only the key/counter increment loops back, so back-to-back beats are hashed in flight
// a stalled result freezes the whole chain; in_ready drops while the output waits
// reset clears seeds, key, counter and all valid bits; cfg_ready is always high
module pseudo_des_counter_rng_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [psdes_pkg::WORD_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [psdes_pkg::WORD_W-1:0] random_word,
	output logic [psdes_pkg::FRAC_W-1:0] unit_fraction
);

	psdes_pkg::beat_t chain [psdes_pkg::ROUND_COUNT+1];

	logic                         en;
	logic                         draw_fire;
	logic                         out_valid_q;
	logic [psdes_pkg::WORD_W-1:0] word_q;

	// chain advances whenever the output slot is free or being emptied
	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign draw_fire = in_valid && en;
	assign cfg_ready = 1'b1;

	psdes_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_fire  (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.draw_fire (draw_fire),
		.restart   (restart),
		.beat_out  (chain[0])
	);

	// row of round cells, each handing its block to the next
	for (genvar r = 0; r < psdes_pkg::ROUND_COUNT; r++) begin : g_round
		psdes_round_cell #(
			.ROUND (r)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.beat_in  (chain[r]),
			.beat_out (chain[r+1])
		);
	end

	// output register; the final right half is the hash word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[psdes_pkg::ROUND_COUNT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= chain[psdes_pkg::ROUND_COUNT].right;
		end
	end

	assign out_valid     = out_valid_q;
	assign random_word   = word_q;
	// word >> 9 with the low bit forced on, never zero
	assign unit_fraction = {word_q[psdes_pkg::WORD_W-1:10], 1'b1};

endmodule

// ===== hdl/psdes_round_cell.sv =====
// one feistel round of the pseudo-des hash, two register stages
// depends on psdes_pkg
module psdes_round_cell #(
	parameter int unsigned ROUND = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  psdes_pkg::beat_t beat_in,
	output psdes_pkg::beat_t beat_out
);

	localparam logic [psdes_pkg::WORD_W-1:0] KIN  = psdes_pkg::XOR_IN[ROUND];
	localparam logic [psdes_pkg::WORD_W-1:0] KOUT = psdes_pkg::XOR_OUT[ROUND];

	logic [psdes_pkg::WORD_W-1:0] a;
	logic [psdes_pkg::HALF_W-1:0] lo, hi;

	logic                         valid_s1;
	logic [psdes_pkg::WORD_W-1:0] left_s1, right_s1;
	logic [psdes_pkg::WORD_W-1:0] ll_s1, hh_s1, lh_s1;

	logic [psdes_pkg::WORD_W-1:0] b, swapped, f;

	logic                         valid_s2;
	logic [psdes_pkg::WORD_W-1:0] left_s2, right_s2;

	assign a  = beat_in.right ^ KIN;
	assign lo = a[psdes_pkg::HALF_W-1:0];
	assign hi = a[psdes_pkg::WORD_W-1:psdes_pkg::HALF_W];

	// stage 1: the three half squares and products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s1  <= beat_in.left;
			right_s1 <= beat_in.right;
			ll_s1    <= 32'(lo) * 32'(lo);
			hh_s1    <= 32'(hi) * 32'(hi);
			lh_s1    <= 32'(lo) * 32'(hi);
		end
	end

	// stage 2: combine, swap halves, mix into the left half
	assign b       = ll_s1 + ~hh_s1;
	assign swapped = {b[psdes_pkg::HALF_W-1:0], b[psdes_pkg::WORD_W-1:psdes_pkg::HALF_W]};
	assign f       = (swapped ^ KOUT) + lh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s2  <= right_s1;
			right_s2 <= left_s1 ^ f;
		end
	end

	assign beat_out.valid = valid_s2;
	assign beat_out.left  = left_s2;
	assign beat_out.right = right_s2;

endmodule

// ===== hdl/psdes_state.sv =====
// seed registers and the key/counter pair that feed the round chain
// depends on psdes_pkg and the assertion macro header
`include "pseudo_des_counter_rng_core_macros.svh"

module psdes_state (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_fire,
	input  logic                         cfg_index,
	input  logic [psdes_pkg::WORD_W-1:0] cfg_data,
	input  logic                         draw_fire,
	input  logic                         restart,
	output psdes_pkg::beat_t             beat_out
);

	logic [psdes_pkg::WORD_W-1:0] key_seed_q, counter_seed_q;
	logic [psdes_pkg::WORD_W-1:0] key_q, counter_q;
	logic [psdes_pkg::WORD_W-1:0] key_cur, counter_cur, counter_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q     <= '0;
			counter_seed_q <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				psdes_pkg::CFG_KEY_SEED:     key_seed_q     <= cfg_data;
				psdes_pkg::CFG_COUNTER_SEED: counter_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// restart reloads before this draw is hashed
	assign key_cur     = restart ? key_seed_q : key_q;
	assign counter_cur = restart ? counter_seed_q : counter_q;
	assign counter_nxt = counter_cur + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			counter_q <= '0;
		end else if (draw_fire) begin
			counter_q <= counter_nxt;
			// counter wrap carries into the key
			key_q     <= key_cur + 32'(counter_nxt == '0);
		end
	end

	assign beat_out.valid = draw_fire;
	assign beat_out.left  = key_cur;
	assign beat_out.right = counter_cur;

	`PSDES_ASSERT_NEXT(a_restart_load, draw_fire && restart, counter_q == $past(counter_seed_q) + 32'd1, "counter not reloaded from seed")
	`PSDES_ASSERT_NEXT(a_count_step, draw_fire && !restart, counter_q == $past(counter_q) + 32'd1, "counter did not step")
	`PSDES_ASSERT_NEXT(a_idle_hold, !draw_fire, $stable(key_q) && $stable(counter_q), "state moved without a draw")

endmodule

// ===== test/psdes_draw_checker.sv =====
// result checker for the pseudo-des counter rng core: tracks seeds, key and counter
// from the channel beats, predicts each draw and compares the result beats in order
// depends on psdes_pkg
module psdes_draw_checker
	import psdes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              restart,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [WORD_W-1:0] random_word,
	input  logic [FRAC_W-1:0] unit_fraction,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [FRAC_W-1:0] frac;
	} draw_result_t;

	draw_result_t      expected_draws [$];
	logic [WORD_W-1:0] key_seed_m     = '0;
	logic [WORD_W-1:0] counter_seed_m = '0;
	logic [WORD_W-1:0] key_word_m     = '0;
	logic [WORD_W-1:0] draw_count_m   = '0;
	int                errors         = 0;

	// one feistel round function, all products modulo 2^32
	function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] x,
			input int unsigned r);
		logic [WORD_W-1:0] a, lo, hi, sq_sum, swapped;
		a       = x ^ XOR_IN[r];
		lo      = {16'h0000, a[15:0]};
		hi      = {16'h0000, a[31:16]};
		sq_sum  = (lo * lo) + ~(hi * hi);
		swapped = {sq_sum[15:0], sq_sum[31:16]};
		return (swapped ^ XOR_OUT[r]) + (lo * hi);
	endfunction

	function automatic draw_result_t hash_draw(input logic [WORD_W-1:0] key,
			input logic [WORD_W-1:0] count);
		logic [WORD_W-1:0] left, right, mixed;
		draw_result_t      res;
		left  = key;
		right = count;
		for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
			mixed = left ^ round_mix(right, r);
			left  = right;
			right = mixed;
		end
		res.word = right;
		res.frac = {right[31:10], 1'b1};
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		draw_result_t want;
		if (!arst_n) begin
			expected_draws.delete();
			key_seed_m     = '0;
			counter_seed_m = '0;
			key_word_m     = '0;
			draw_count_m   = '0;
			errors         = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_KEY_SEED)
					key_seed_m = cfg_data;
				else if (cfg_index == CFG_COUNTER_SEED)
					counter_seed_m = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (restart) begin
					key_word_m   = key_seed_m;
					draw_count_m = counter_seed_m;
				end
				expected_draws.insert(expected_draws.size(),
					hash_draw(key_word_m, draw_count_m));
				draw_count_m = draw_count_m + 32'd1;
				// counter wrap carries into the key
				if (draw_count_m == '0)
					key_word_m = key_word_m + 32'd1;
			end
			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					$error("result beat with no draw pending: random_word %h", random_word);
					errors++;
				end else begin
					want = expected_draws.pop_front();
					if (random_word !== want.word) begin
						$error("random_word expected %h actual %h", want.word, random_word);
						errors++;
					end
					if (unit_fraction !== want.frac) begin
						$error("unit_fraction expected %h actual %h", want.frac,
							unit_fraction);
						errors++;
					end
				end
			end
			outstanding <= expected_draws.size();
			mismatches  <= errors;
		end
	end

endmodule

// ===== test/tb.sv =====
// testbench top for pseudo_des_counter_rng_core: clock, reset, seed writes, draw beats
// and result back-pressure; depends on psdes_pkg, the core and psdes_draw_checker
// draws are checked in psdes_draw_checker, this module only drives and gives the verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psdes_pkg::*;

	localparam int PHASES      = 12;
	localparam int PHASE_DRAWS = 155;
	localparam int LONG_HOLD   = 64;      // receiver stall long enough to fill the chain
	localparam int TAIL_CYCLES = 16;      // idle time after the last drain before the verdict
	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              restart;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] random_word;
	logic [FRAC_W-1:0] unit_fraction;

	int fail_total;
	int pending;
	int cycle_count = 0;

	// shared knobs between the draw source and the result sink
	logic steady_flow   = 1'b0;  // no short random gaps on either side while set
	logic stall_request = 1'b0;  // asks the sink for one long hold-off

	pseudo_des_counter_rng_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_word  (random_word),
		.unit_fraction(unit_fraction)
	);

	psdes_draw_checker draw_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_word  (random_word),
		.unit_fraction(unit_fraction),
		.mismatches   (fail_total),
		.outstanding  (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop in case the core hangs or results go missing
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// result sink: random hold-off before each beat, now and then a long one
	initial begin : result_sink
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		gap = 0;
		forever begin
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			// beat taken at this edge, pick the next hold-off
			if (stall_request) begin
				gap = LONG_HOLD;
				stall_request <= 1'b0;
			end else if ($urandom_range(0, 299) == 0)
				gap = LONG_HOLD;
			else if (steady_flow)
				gap = 0;
			else
				gap = $urandom_range(0, 10);
		end
	end

	// offer one draw beat after a random gap; valid stays up across back-to-back beats
	task automatic offer_draw(input logic reload);
		int unsigned gap;
		gap = steady_flow ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= reload;
		do @(posedge clk); while (!in_ready);
	endtask

	// close the draw stream and wait until every result beat has come back
	task automatic drain_draws();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// seed writes, only called with nothing in flight; valid drops once at the end
	task automatic load_seeds(input logic wr_key, input logic [WORD_W-1:0] key,
			input logic wr_count, input logic [WORD_W-1:0] count);
		if (wr_key) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_KEY_SEED;
			cfg_data  <= key;
			do @(posedge clk); while (!cfg_ready);
		end
		if (wr_count) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_COUNTER_SEED;
			cfg_data  <= count;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [WORD_W-1:0] key, count;
		logic              wr_key, wr_count;
		logic              reload;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KEY_SEED;
		cfg_data  = '0;
		in_valid  = 1'b0;
		restart   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset state is all zero, a restart with zero seeds must repeat the first word
		offer_draw(1'b0);
		offer_draw(1'b1);
		drain_draws();

		// seed writes alone leave key and counter alone until a restart beat
		load_seeds(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE);
		offer_draw(1'b0);
		// counter runs through all ones into zero, and the key wraps with it
		offer_draw(1'b1);
		offer_draw(1'b0);
		offer_draw(1'b0);
		offer_draw(1'b0);
		drain_draws();

		// only the key seed changes, counter seed still just below the wrap
		load_seeds(1'b1, 32'h0000_0000, 1'b0, '0);
		offer_draw(1'b1);
		offer_draw(1'b0);
		offer_draw(1'b0);
		drain_draws();

		// alternating bit patterns, back to back
		steady_flow <= 1'b1;
		load_seeds(1'b1, 32'h5555_AAAA, 1'b1, 32'hAAAA_5555);
		offer_draw(1'b1);
		offer_draw(1'b0);
		offer_draw(1'b0);
		drain_draws();

		// counter equal to the first round constant zeroes the first round input
		steady_flow <= 1'b0;
		load_seeds(1'b0, '0, 1'b1, XOR_IN[0]);
		offer_draw(1'b1);
		offer_draw(1'b0);
		drain_draws();

		// --- random part: a fresh seed setting per phase ---
		for (int ph = 0; ph < PHASES; ph++) begin
			wr_key   = 1'b1;
			wr_count = 1'b1;
			key      = $urandom;
			count    = $urandom;
			case ($urandom_range(0, 4))
				0: ;
				1: begin
					key   = '0;
					count = '0;
				end
				2: begin
					key   = '1;
					count = '1;
				end
				// counter close to the wrap so the key carry shows up in the phase
				3: count = 32'hFFFF_FFFF - $urandom_range(0, 40);
				default: begin
					wr_key   = $urandom_range(0, 1);
					wr_count = !wr_key;
				end
			endcase
			load_seeds(wr_key, key, wr_count, count);

			// phase 1 runs flat out while the sink holds off, so the core backs up
			if (ph == 1) begin
				steady_flow   <= 1'b1;
				stall_request <= 1'b1;
			end else
				steady_flow <= ($urandom_range(0, 3) == 0);

			for (int n = 0; n < PHASE_DRAWS; n++) begin
				if (n == 0)
					reload = ($urandom_range(0, 3) != 0);
				else
					reload = ($urandom_range(0, 15) == 0);
				offer_draw(reload);
			end
			drain_draws();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/psdes_pkg.sv
hdl/psdes_round_cell.sv
hdl/psdes_state.sv
hdl/pseudo_des_counter_rng_core.sv
test/psdes_draw_checker.sv
test/tb.sv
